@@ src/lms_pkg.sv @@
// ----------------------------------------------------------------------------
// lms_pkg: shared types and constants for the LCD mode/line sequencer
// Mode codes, one-hot sequencer states, register indexes and the result beat.
// ----------------------------------------------------------------------------
package lms_pkg;

  // Mode codes as seen on the result channel
  typedef enum logic [1:0] {
    LCD_HBLANK = 2'd0,
    LCD_VBLANK = 2'd1,
    LCD_OAM    = 2'd2,
    LCD_VRAM   = 2'd3
  } lcd_mode_e;

  // One-hot sequencer state
  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_VRAM   = 4'b1000
  } mode_state_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COMPARE_LINE = 3'd0,
    REG_COIN_IRQ_EN  = 3'd1,
    REG_OAM_CYCLES   = 3'd2,
    REG_VRAM_CYCLES  = 3'd3,
    REG_HBLANK_CYCLES = 3'd4,
    REG_LINE_CYCLES  = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned DurW     = 10;
  localparam int unsigned CdW      = 12;

  localparam logic [DurW-1:0] OAM_CYCLES_RST    = 10'd80;
  localparam logic [DurW-1:0] VRAM_CYCLES_RST   = 10'd172;
  localparam logic [DurW-1:0] HBLANK_CYCLES_RST = 10'd204;
  localparam logic [DurW-1:0] LINE_CYCLES_RST   = 10'd456;

  // One result beat
  typedef struct packed {
    lcd_mode_e  mode;
    logic [7:0] line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
  } result_t;

  function automatic lcd_mode_e state_to_code(input mode_state_e st);
    lcd_mode_e code;
    case (st)
      ST_HBLANK: code = LCD_HBLANK;
      ST_VBLANK: code = LCD_VBLANK;
      ST_OAM:    code = LCD_OAM;
      default:   code = LCD_VRAM;
    endcase
    return code;
  endfunction

endpackage

@@ src/lms_result_buf.sv @@
// ----------------------------------------------------------------------------
// lms_result_buf: two-entry result buffer
// Decouples the step logic from the result channel; ready is registered.
// ----------------------------------------------------------------------------
module lms_result_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lms_pkg::result_t push_data_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lms_pkg::result_t out_data_o
);
  import lms_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign space_o     = (count_q != 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o) else $error("push into full result buffer");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("result buffer count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result buffer pointers out of step");
`endif

endmodule

@@ src/lcd_mode_line_sequencer.sv @@
// ----------------------------------------------------------------------------
// lcd_mode_line_sequencer: LCD mode and scanline timing
// Counts down machine cycles and walks OAM/VRAM/HBLANK/VBLANK per line.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o   | elapsed_cycles_i
//  out     | output    | out_valid_o / out_ready_i | lcd_mode_o, line_number_o,
//          |           |                           | coincidence_o, vblank_irq_o,
//          |           |                           | stat_irq_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat accepted per cycle while in_ready_o is high; its result is registered.
// The countdown/mode update is a single subtract, saturate and add per beat.
// A two-entry result buffer holds results while out stalls; in_ready_o drops
// only when both entries are full. cfg_ready_o is always high.
// Reset: countdown 0, mode OAM, line 0, flag 0, durations 80/172/204/456.
// ----------------------------------------------------------------------------
module lcd_mode_line_sequencer #(
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned LAST_LINE     = 153
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    elapsed_cycles_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    lcd_mode_o,
  output logic [7:0]                    line_number_o,
  output logic                          coincidence_o,
  output logic                          vblank_irq_o,
  output logic                          stat_irq_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lms_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lms_pkg::*;

  localparam logic [7:0] VisLine  = 8'(VISIBLE_LINES);
  localparam logic [7:0] LastLine = 8'(LAST_LINE);
  localparam logic signed [CdW:0] CdMin13 = -13'sd2048;

  // configuration
  logic [7:0]      cmp_line_q;
  logic            irq_en_q;
  logic [DurW-1:0] oam_cyc_q, vram_cyc_q, hblank_cyc_q, line_cyc_q;

  // sequencer state
  logic signed [CdW-1:0] cd_q, cd_d;
  mode_state_e           mode_q, mode_d;
  logic [7:0]            line_q, line_d;
  logic                  coin_q, coin_d;

  logic                  accept;
  logic signed [CdW:0]   cd_sub;
  logic signed [CdW-1:0] cd_sat;
  logic                  expired;
  logic [7:0]            line_inc;
  logic [7:0]            cmp_src;
  logic                  do_cmp;
  logic                  match;
  logic [DurW-1:0]       add;
  logic                  vbl, stat;
  result_t               res;
  result_t               out_res;

  assign cfg_ready_o = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_line_q   <= 8'd0;
      irq_en_q     <= 1'b0;
      oam_cyc_q    <= OAM_CYCLES_RST;
      vram_cyc_q   <= VRAM_CYCLES_RST;
      hblank_cyc_q <= HBLANK_CYCLES_RST;
      line_cyc_q   <= LINE_CYCLES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COMPARE_LINE:  cmp_line_q   <= cfg_data_i[7:0];
        REG_COIN_IRQ_EN:   irq_en_q     <= cfg_data_i[0];
        REG_OAM_CYCLES:    oam_cyc_q    <= cfg_data_i;
        REG_VRAM_CYCLES:   vram_cyc_q   <= cfg_data_i;
        REG_HBLANK_CYCLES: hblank_cyc_q <= cfg_data_i;
        REG_LINE_CYCLES:   line_cyc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // countdown subtract with saturation at the negative limit
  assign cd_sub  = {cd_q[CdW-1], cd_q} - $signed({5'd0, elapsed_cycles_i});
  assign cd_sat  = (cd_sub < CdMin13) ? CdMin13[CdW-1:0] : cd_sub[CdW-1:0];
  assign expired = cd_sat[CdW-1] || (cd_sat == '0);
  assign line_inc = line_q + 8'd1;

  // mode transition
  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    add     = '0;
    vbl     = 1'b0;
    do_cmp  = 1'b0;
    cmp_src = line_q;
    if (expired) begin
      case (mode_q)
        ST_HBLANK: begin
          line_d  = line_inc;
          cmp_src = line_inc;
          do_cmp  = 1'b1;
          if (line_inc < VisLine) begin
            mode_d = ST_OAM;
            add    = oam_cyc_q;
          end else begin
            vbl    = 1'b1;
            mode_d = ST_VBLANK;
            add    = line_cyc_q;
          end
        end
        ST_VBLANK: begin
          do_cmp = 1'b1;
          if (line_q < LastLine) begin
            line_d = line_inc;
            add    = line_cyc_q;
          end else begin
            line_d = 8'd0;
            mode_d = ST_OAM;
            add    = oam_cyc_q;
          end
        end
        ST_OAM: begin
          mode_d = ST_VRAM;
          add    = vram_cyc_q;
        end
        default: begin
          do_cmp = 1'b1;
          mode_d = ST_HBLANK;
          add    = hblank_cyc_q;
        end
      endcase
    end
  end

  // line compare and countdown reload
  assign match  = (cmp_src == cmp_line_q);
  assign coin_d = do_cmp ? match : coin_q;
  assign stat   = do_cmp && match && irq_en_q;
  assign cd_d   = expired ? (cd_sat + $signed({2'd0, add})) : cd_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q   <= '0;
      mode_q <= ST_OAM;
      line_q <= 8'd0;
      coin_q <= 1'b0;
    end else if (accept) begin
      cd_q   <= cd_d;
      mode_q <= mode_d;
      line_q <= line_d;
      coin_q <= coin_d;
    end
  end

  // result beat
  always_comb begin
    res.mode        = state_to_code(mode_d);
    res.line        = line_d;
    res.coincidence = coin_d;
    res.vblank_irq  = vbl;
    res.stat_irq    = stat;
  end

  lms_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign lcd_mode_o    = out_res.mode;
  assign line_number_o = out_res.line;
  assign coincidence_o = out_res.coincidence;
  assign vblank_irq_o  = out_res.vblank_irq;
  assign stat_irq_o    = out_res.stat_irq;

`ifndef SYNTH
  a_vbl_enters_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && vbl) |=> (mode_q == ST_VBLANK && line_q == VisLine))
    else $error("vblank pulse without entering vblank");
  a_stat_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stat) |=> coin_q) else $error("stat pulse without coincidence");
  a_cd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_q <= $signed(12'sd1023)) else $error("countdown above max duration");
`endif

endmodule
